### src/huffman_tree_decoder_core_assert.svh
// Assertion macros used by the decoder controller.
// The using module must provide clk and arst_n.
`ifndef HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define HFD_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("hfd: invariant violated");

// Same-cycle implication.
`define HFD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hfd: implication violated");

// Next-cycle implication.
`define HFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hfd: sequence violated");

`endif

### src/hfd_pkg.sv
package hfd_pkg;

	localparam int DEF_MAX_NODES = 512;
	localparam int MAX_CODE_BITS = 32;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  entry_symbol;
		logic [5:0]  code_length;
		logic [31:0] code_bits;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       finished;
		logic       error;
	} result_t;

	// result request from the walker to the result buffer
	typedef struct packed {
		logic       push;
		logic       flush;
		logic [7:0] symbol;
		logic       finished;
		logic       error;
	} res_req_t;

endpackage

### src/hfd_node_mem.sv
module hfd_node_mem #(
	parameter int DEPTH = hfd_pkg::DEF_MAX_NODES,
	parameter int WIDTH = 27
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] store_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= store_q[raddr];
		end
	end

endmodule

### src/hfd_result_q.sv
module hfd_result_q (
	input  logic              clk,
	input  logic              arst_n,
	input  hfd_pkg::res_req_t req,
	output logic              valid,
	output hfd_pkg::result_t  result
);

	logic             pend_v_q;
	hfd_pkg::result_t pend_q;
	logic             out_v_q;
	hfd_pkg::result_t out_q;

	// one item of lookahead: a result leaves only once it is known whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= pend_v_q && (req.push || req.flush);
			if (req.push) begin
				pend_v_q <= 1'b1;
			end else if (req.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q && (req.push || req.flush)) begin
			out_q <= '{symbol: pend_q.symbol, last: req.flush,
				finished: pend_q.finished, error: pend_q.error};
		end
		if (req.push) begin
			pend_q.symbol   <= req.symbol;
			pend_q.last     <= 1'b0;
			pend_q.finished <= req.finished;
			pend_q.error    <= req.error;
		end
	end

	assign valid  = out_v_q;
	assign result = out_q;

endmodule

### src/hfd_ctrl.sv
module hfd_ctrl #(
	parameter int MAX_NODES = hfd_pkg::DEF_MAX_NODES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  hfd_pkg::item_t                        item,
	input  logic [31:0]                           symbol_count,
	output logic                                  busy,
	output logic                                  mem_re,
	output logic [$clog2(MAX_NODES)-1:0]          mem_raddr,
	input  logic [8+2*$clog2(MAX_NODES):0]        mem_rdata,
	output logic                                  mem_we,
	output logic [$clog2(MAX_NODES)-1:0]          mem_waddr,
	output logic [8+2*$clog2(MAX_NODES):0]        mem_wdata,
	output hfd_pkg::res_req_t                     req
);

	`include "huffman_tree_decoder_core_assert.svh"

	localparam int IW  = $clog2(MAX_NODES);
	localparam int NUW = $clog2(MAX_NODES + 1);

	typedef struct packed {
		logic          leaf;
		logic [7:0]    sym;
		logic [IW-1:0] c1;
		logic [IW-1:0] c0;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_E_CHK,
		ST_E_WNEW,
		ST_E_WPAR,
		ST_D_STEP,
		ST_D_WALK,
		ST_FLUSH
	} state_t;

	state_t         state_q;
	logic [NUW-1:0] nodes_used_q;
	logic [IW-1:0]  cur_q;
	logic [31:0]    remaining_q;
	logic [IW-1:0]  root0_q;
	logic [IW-1:0]  root1_q;

	logic [IW-1:0]  p_q;
	logic [IW-1:0]  cand_q;
	logic [31:0]    code_q;
	logic [5:0]     bits_left_q;
	logic [7:0]     sym_q;
	logic [7:0]     byte_q;
	logic [3:0]     byte_bits_q;
	logic           dir_q;
	node_t          par_q;

	node_t          rd_node;
	node_t          root_node;
	node_t          e_node;
	node_t          d_node;
	node_t          par_upd;
	node_t          new_node;
	logic           accept;
	logic           e_dir;
	logic           e_final;
	logic [IW-1:0]  e_child;
	logic [IW-1:0]  d_child;
	logic [IW-1:0]  w_child;
	logic           full;
	logic           too_long;
	logic           e_fail;
	logic           last_bit;
	logic           rem_dec;

	// root lives in flops; memory entry 0 is never used
	assign rd_node   = node_t'(mem_rdata);
	assign root_node = '{leaf: 1'b0, sym: 8'd0, c1: root1_q, c0: root0_q};
	assign e_node    = (p_q == '0) ? root_node : rd_node;
	assign d_node    = (cur_q == '0) ? root_node : rd_node;

	assign accept   = start && (state_q == ST_IDLE);
	assign e_dir    = code_q[0];
	assign e_final  = (bits_left_q == 6'd1);
	assign e_child  = e_dir ? e_node.c1 : e_node.c0;
	assign d_child  = byte_q[0] ? d_node.c1 : d_node.c0;
	assign w_child  = byte_q[1] ? rd_node.c1 : rd_node.c0;
	assign full     = (nodes_used_q == NUW'(MAX_NODES));
	assign too_long = ({1'b0, item.code_length} > 7'(hfd_pkg::MAX_CODE_BITS));
	assign e_fail   = e_node.leaf || ((e_child == '0) && full) || ((e_child != '0) && e_final);
	assign last_bit = (byte_bits_q == 4'd1);

	always_comb begin
		par_upd = par_q;
		if (dir_q) begin
			par_upd.c1 = cand_q;
		end else begin
			par_upd.c0 = cand_q;
		end
		new_node.leaf = e_final;
		new_node.sym  = e_final ? sym_q : 8'd0;
		new_node.c1   = '0;
		new_node.c0   = '0;
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		req       = '0;
		rem_dec   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (item.kind == hfd_pkg::KIND_DATA) &&
						(remaining_q != '0) && (cur_q != '0)) begin
					mem_re    = 1'b1;
					mem_raddr = cur_q;
				end
				if (accept && (item.kind == hfd_pkg::KIND_ENTRY) &&
						(item.code_length != '0) && too_long) begin
					req.push  = 1'b1;
					req.error = 1'b1;
				end
			end
			ST_E_CHK: begin
				if (e_fail) begin
					req.push  = 1'b1;
					req.error = 1'b1;
				end else if (e_child != '0) begin
					mem_re    = 1'b1;
					mem_raddr = e_child;
				end
			end
			ST_E_WNEW: begin
				mem_we    = 1'b1;
				mem_waddr = cand_q;
				mem_wdata = new_node;
			end
			ST_E_WPAR: begin
				if (p_q != '0) begin
					mem_we    = 1'b1;
					mem_waddr = p_q;
					mem_wdata = par_upd;
				end
				if (!e_final) begin
					mem_re    = 1'b1;
					mem_raddr = cand_q;
				end
			end
			ST_D_STEP: begin
				if (d_child == '0) begin
					req.push  = 1'b1;
					req.error = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = d_child;
				end
			end
			ST_D_WALK: begin
				if (rd_node.leaf) begin
					req.push     = 1'b1;
					req.symbol   = rd_node.sym;
					req.finished = (remaining_q == 32'd1);
					rem_dec      = 1'b1;
				end else if (!last_bit && (w_child == '0)) begin
					req.push  = 1'b1;
					req.error = 1'b1;
				end else if (!last_bit) begin
					mem_re    = 1'b1;
					mem_raddr = w_child;
				end
			end
			ST_FLUSH: begin
				req.flush = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nodes_used_q <= NUW'(1);
			cur_q        <= '0;
			remaining_q  <= '0;
			root0_q      <= '0;
			root1_q      <= '0;
		end else begin
			if (rem_dec) begin
				remaining_q <= remaining_q - 32'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.kind)
							hfd_pkg::KIND_CLEAR: begin
								root0_q      <= '0;
								root1_q      <= '0;
								nodes_used_q <= NUW'(1);
								cur_q        <= '0;
								remaining_q  <= symbol_count;
							end
							hfd_pkg::KIND_ENTRY: begin
								if (item.code_length == '0) begin
									state_q <= ST_IDLE;
								end else if (too_long) begin
									state_q <= ST_FLUSH;
								end else begin
									state_q <= ST_E_CHK;
								end
							end
							hfd_pkg::KIND_DATA: begin
								if (remaining_q != '0) begin
									state_q <= ST_D_STEP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_E_CHK: begin
					if (e_fail) begin
						state_q <= ST_FLUSH;
					end else if (e_child == '0) begin
						state_q <= ST_E_WNEW;
					end
				end
				ST_E_WNEW: begin
					nodes_used_q <= nodes_used_q + NUW'(1);
					state_q      <= ST_E_WPAR;
				end
				ST_E_WPAR: begin
					if (p_q == '0) begin
						if (dir_q) begin
							root1_q <= cand_q;
						end else begin
							root0_q <= cand_q;
						end
					end
					state_q <= e_final ? ST_IDLE : ST_E_CHK;
				end
				ST_D_STEP: begin
					if (d_child == '0) begin
						cur_q   <= '0;
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_D_WALK;
					end
				end
				ST_D_WALK: begin
					if (rd_node.leaf) begin
						cur_q   <= '0;
						state_q <= (last_bit || (remaining_q == 32'd1)) ? ST_FLUSH : ST_D_STEP;
					end else if (last_bit) begin
						cur_q   <= cand_q;
						state_q <= ST_FLUSH;
					end else if (w_child == '0) begin
						cur_q   <= '0;
						state_q <= ST_FLUSH;
					end else begin
						cur_q <= cand_q;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					p_q         <= '0;
					code_q      <= item.code_bits;
					bits_left_q <= item.code_length;
					sym_q       <= item.entry_symbol;
					byte_q      <= item.data_byte;
					byte_bits_q <= 4'd8;
				end
			end
			ST_E_CHK: begin
				if (e_child == '0) begin
					cand_q <= nodes_used_q[IW-1:0];
					dir_q  <= e_dir;
					par_q  <= e_node;
				end else begin
					p_q         <= e_child;
					code_q      <= code_q >> 1;
					bits_left_q <= bits_left_q - 6'd1;
				end
			end
			ST_E_WPAR: begin
				p_q         <= cand_q;
				code_q      <= code_q >> 1;
				bits_left_q <= bits_left_q - 6'd1;
			end
			ST_D_STEP: begin
				cand_q <= d_child;
			end
			ST_D_WALK: begin
				byte_q      <= byte_q >> 1;
				byte_bits_q <= byte_bits_q - 4'd1;
				cand_q      <= w_child;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`HFD_ASSERT_ALWAYS(a_used_range, (nodes_used_q != '0) && (nodes_used_q <= NUW'(MAX_NODES)))
	`HFD_ASSERT_ALWAYS(a_no_rw_clash, !(mem_re && mem_we && (mem_raddr == mem_waddr)))
	`HFD_ASSERT_IMPL(a_rem_nonzero, rem_dec, remaining_q != '0)
	`HFD_ASSERT_NEXT(a_flush_idle, state_q == ST_FLUSH, state_q == ST_IDLE)

endmodule

### src/huffman_tree_decoder_core.sv
// Huffman tree decoder. Items are taken on start while busy is low; results
// leave on result/result_valid for exactly one cycle each and cannot be held
// off, so the receiver must take every strobe. A clear item empties the tree
// and loads the remaining count from the configuration register. An entry
// item walks its code LSB first: it reads each level that already exists,
// and for each node it creates it checks the level, writes the new node and
// then links it into its parent. A data byte starts the walk and takes one
// node-memory read per bit, returning to the root after each symbol found
// before the last bit; the walk stops early on an error or when the count
// runs out. Walk speed is set by the registered read of the single node
// memory. Data bytes with a nonzero count and failed entries end in a busy
// flush state that marks the final result, which is strobed in the first
// cycle with busy low. Write the configuration register only while idle.
module huffman_tree_decoder_core #(
	parameter int MAX_NODES = hfd_pkg::DEF_MAX_NODES
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration: symbol count
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data,
	// command side
	input  logic             start,
	input  hfd_pkg::item_t   item,
	output logic             busy,
	// result side
	output logic             result_valid,
	output hfd_pkg::result_t result
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = 1 + 8 + 2 * IW;	// leaf, symbol, two child links

	logic [31:0]       symbol_count_q;
	logic              mem_re;
	logic [IW-1:0]     mem_raddr;
	logic [NW-1:0]     mem_rdata;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [NW-1:0]     mem_wdata;
	hfd_pkg::res_req_t req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= '0;
		end else if (cfg_wr_en) begin
			symbol_count_q <= cfg_wr_data;
		end
	end

	// node store: link value 0 means no child, the root is kept in flops
	hfd_node_mem #(
		.DEPTH (MAX_NODES),
		.WIDTH (NW)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	// tree build and bit walk sequencer
	hfd_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.symbol_count (symbol_count_q),
		.busy         (busy),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.req          (req)
	);

	// holds one result back so the last flag can be set
	hfd_result_q u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.valid  (result_valid),
		.result (result)
	);

endmodule
